[rtl/cacm_pkg.sv]
// Shared types and constants for the CDC ACM receive and control block.
// Used by cacm_ctrl, cacm_datapath and cdc_acm_receive_and_control.
`timescale 1ns / 1ps

package cacm_pkg;

  localparam logic [2:0] CMD_BUS_RESET = 3'd0;
  localparam logic [2:0] CMD_ENUM_DONE = 3'd1;
  localparam logic [2:0] CMD_DATA      = 3'd2;
  localparam logic [2:0] CMD_SETUP     = 3'd3;
  localparam logic [2:0] CMD_POP       = 3'd4;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_POP     = 2'd1;
  localparam logic [1:0] KIND_CTRL_IN = 2'd2;
  localparam logic [1:0] KIND_ZLP     = 2'd3;

  localparam logic [7:0] REQ_SET_CODING = 8'h20;
  localparam logic [7:0] REQ_GET_CODING = 8'h21;
  localparam logic [7:0] REQ_SET_CTRL   = 8'h22;

  localparam logic [3:0] EP_CTRL      = 4'd0;
  localparam logic [3:0] EP_DATA      = 4'd1;
  localparam logic [3:0] PKT_OUT_DATA = 4'd2;
  localparam logic [3:0] PKT_SETUP    = 4'd6;

  localparam logic [1:0] REG_BAUD     = 2'd0;
  localparam logic [1:0] REG_STOP_FMT = 2'd1;
  localparam logic [1:0] REG_PARITY   = 2'd2;
  localparam logic [1:0] REG_CHAR_LEN = 2'd3;

  localparam logic [31:0] BAUD_RESET     = 32'd115200;
  localparam logic [4:0]  CHAR_LEN_RESET = 5'd8;

  localparam int CODING_BYTES = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_CODING
  } state_t;

  typedef struct packed {
    logic load_item;
    logic commit_simple;
    logic mem_read;
    logic commit_pop;
    logic emit_coding;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       is_get_coding;
    logic       fifo_empty;
    logic       coding_last;
    logic       out_free;
  } dp_status_t;

endpackage

[rtl/cacm_ctrl.sv]
// Controller state machine for the CDC ACM receive and control block.
// Drives cacm_datapath through dp_cmd_t; depends on cacm_pkg.
`timescale 1ns / 1ps

module cacm_ctrl import cacm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load_item = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.cmd == CMD_POP && !status.fifo_empty) begin
          cmd.mem_read = 1'b1;
          state_next   = ST_POP;
        end else if (status.is_get_coding) begin
          state_next = ST_CODING;
        end else if (status.out_free) begin
          cmd.commit_simple = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      ST_POP: begin
        if (status.out_free) begin
          cmd.commit_pop = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_CODING: begin
        if (status.out_free) begin
          cmd.emit_coding = 1'b1;
          if (status.coding_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/cacm_datapath.sv]
// Datapath: request register, receive FIFO memory and pointers, link state,
// line coding registers and the result register. Depends on cacm_pkg.
`timescale 1ns / 1ps

module cacm_datapath import cacm_pkg::*; #(
  parameter int RX_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [2:0]  in_command,
  input  logic [39:0] in_data,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic        out_last,
  output logic [23:0] out_data
);

  localparam int PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int DW = PW + 1;
  localparam int FW = (DW > 8) ? DW : 8;

  logic [2:0]  it_cmd;
  logic [3:0]  it_ep;
  logic [3:0]  it_stat;
  logic [7:0]  it_byte;
  logic [7:0]  it_req;
  logic [15:0] it_value;

  logic [7:0]  mem [RX_DEPTH];
  logic [7:0]  rdata;
  logic [PW-1:0] wp, rp, wp_next, rp_next, wp_inc, rp_inc;
  logic link_cfg, bus_conn, dtr, rts;
  logic link_cfg_next, bus_conn_next, dtr_next, rts_next;

  logic [31:0] baud;
  logic [1:0]  stop_fmt;
  logic [2:0]  parity;
  logic [4:0]  char_len;
  logic [2:0]  coding_idx;
  logic [7:0]  coding_byte;

  logic        setup_ok, full, empty, push, coding_last, load;
  logic [1:0]  res_kind;
  logic [7:0]  res_byte;
  logic        res_valid, res_last, res_drop;
  logic [DW-1:0] diff;
  logic [FW-1:0] fill_ext;
  logic [7:0]  fill_sat;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_cmd   <= in_command;
      it_ep    <= in_data[3:0];
      it_stat  <= in_data[7:4];
      it_byte  <= in_data[15:8];
      it_req   <= in_data[23:16];
      it_value <= in_data[39:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baud     <= BAUD_RESET;
      stop_fmt <= '0;
      parity   <= '0;
      char_len <= CHAR_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BAUD:     baud     <= cfg_data;
        REG_STOP_FMT: stop_fmt <= cfg_data[1:0];
        REG_PARITY:   parity   <= cfg_data[2:0];
        REG_CHAR_LEN: char_len <= cfg_data[4:0];
      endcase
    end
  end

  assign wp_inc   = (wp == PW'(RX_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign rp_inc   = (rp == PW'(RX_DEPTH - 1)) ? '0 : rp + 1'b1;
  assign full     = (wp_inc == rp);
  assign empty    = (wp == rp);
  assign setup_ok = (it_ep == EP_CTRL) && (it_stat == PKT_SETUP);
  assign coding_last = (coding_idx == 3'(CODING_BYTES - 1));

  always_comb begin
    case (coding_idx)
      3'd0:    coding_byte = baud[7:0];
      3'd1:    coding_byte = baud[15:8];
      3'd2:    coding_byte = baud[23:16];
      3'd3:    coding_byte = baud[31:24];
      3'd4:    coding_byte = {6'd0, stop_fmt};
      3'd5:    coding_byte = {5'd0, parity};
      default: coding_byte = {3'd0, char_len};
    endcase
  end

  always_comb begin
    wp_next       = wp;
    rp_next       = rp;
    link_cfg_next = link_cfg;
    bus_conn_next = bus_conn;
    dtr_next      = dtr;
    rts_next      = rts;
    push          = 1'b0;
    res_kind      = KIND_ACK;
    res_byte      = '0;
    res_valid     = 1'b0;
    res_last      = 1'b1;
    res_drop      = 1'b0;
    if (cmd.commit_simple) begin
      case (it_cmd)
        CMD_BUS_RESET: begin
          link_cfg_next = 1'b0;
          bus_conn_next = 1'b0;
        end
        CMD_ENUM_DONE: bus_conn_next = 1'b1;
        CMD_DATA: begin
          if (it_ep == EP_DATA && it_stat == PKT_OUT_DATA) begin
            if (full) begin
              res_drop = 1'b1;
            end else begin
              push    = 1'b1;
              wp_next = wp_inc;
            end
          end
        end
        CMD_SETUP: begin
          if (setup_ok && it_req == REQ_SET_CTRL) begin
            dtr_next      = it_value[0];
            rts_next      = it_value[1];
            link_cfg_next = 1'b1;
            res_kind      = KIND_ZLP;
          end
        end
        CMD_POP: res_kind = KIND_POP;
        default: res_kind = KIND_ACK;
      endcase
    end else if (cmd.commit_pop) begin
      rp_next   = rp_inc;
      res_kind  = KIND_POP;
      res_byte  = rdata;
      res_valid = 1'b1;
    end else if (cmd.emit_coding) begin
      res_kind  = KIND_CTRL_IN;
      res_byte  = coding_byte;
      res_valid = 1'b1;
      res_last  = coding_last;
    end
  end

  always_comb begin
    diff = {1'b0, wp_next} - {1'b0, rp_next};
    if (diff[DW-1]) begin
      diff = diff + DW'(RX_DEPTH);
    end
    fill_ext = FW'(diff);
    fill_sat = (fill_ext > FW'(255)) ? 8'hFF : fill_ext[7:0];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= it_byte;
    end
    if (cmd.mem_read) begin
      rdata <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      link_cfg   <= 1'b0;
      bus_conn   <= 1'b0;
      dtr        <= 1'b0;
      rts        <= 1'b0;
      coding_idx <= '0;
    end else begin
      wp       <= wp_next;
      rp       <= rp_next;
      link_cfg <= link_cfg_next;
      bus_conn <= bus_conn_next;
      dtr      <= dtr_next;
      rts      <= rts_next;
      if (cmd.load_item) begin
        coding_idx <= '0;
      end else if (cmd.emit_coding) begin
        coding_idx <= coding_idx + 1'b1;
      end
    end
  end

  assign load = cmd.commit_simple | cmd.commit_pop | cmd.emit_coding;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind <= res_kind;
      out_last <= res_last;
      out_data <= {3'd0, res_drop, rts_next, dtr_next, link_cfg_next & bus_conn_next,
                   fill_sat, res_valid, res_byte};
    end
  end

  assign status.cmd           = it_cmd;
  assign status.is_get_coding = (it_cmd == CMD_SETUP) && setup_ok && (it_req == REQ_GET_CODING);
  assign status.fifo_empty    = empty;
  assign status.coding_last   = coding_last;
  assign status.out_free      = !out_valid || out_ready;

  a_push_leaves_slot: assert property (@(posedge clk) disable iff (rst)
    push |=> (wp != rp))
    else $error("write pointer caught up with read pointer");

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    (cmd.mem_read || cmd.commit_pop) |-> !empty)
    else $error("FIFO read while empty");

  a_coding_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_coding |-> (coding_idx <= 3'(CODING_BYTES - 1)))
    else $error("line coding index past last byte");

  a_coding_tail: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_coding && coding_last) |=> (out_valid && out_last))
    else $error("last line coding byte not marked last");

endmodule

[rtl/cdc_acm_receive_and_control.sv]
// Top level of the CDC ACM receive and control block.
// A request is captured in the request register, then its result is loaded into the result
// register; a pop with data first reads the FIFO memory into a registered read stage, and
// GET_LINE_CODING emits seven results in turn, one per cycle when taken by the output.
// A new request is accepted only once the result of the last one has been loaded.
// Reset: rst clears pointers, link state, DTR/RTS and restores line coding defaults;
// FIFO memory contents are left as they are, with no clearing pass.
`timescale 1ns / 1ps

module cdc_acm_receive_and_control import cacm_pkg::*; #(
  parameter int RX_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // endpoint[3:0], packet_status[7:4], data_byte[15:8], request_code[23:16],
  // request_value[39:24]
  input  logic [39:0] s_axis_tdata,
  // command[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0], byte_valid[8], fill_count[16:9], link_up[17], dtr_out[18],
  // rts_out[19], byte_dropped[20], zero[23:21]
  output logic [23:0] m_axis_tdata,
  // result_kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  dp_cmd_t    cmd;
  dp_status_t status;

  cacm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cacm_datapath #(
    .RX_DEPTH (RX_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_command (s_axis_tuser),
    .in_data    (s_axis_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (m_axis_tuser),
    .out_last   (m_axis_tlast),
    .out_data   (m_axis_tdata)
  );

endmodule

[test/cdc_acm_receive_and_control_tb.sv]
// Self-checking testbench for the CDC ACM receive and control block.
// Drives requests from a directed table and a random mix; results are checked against
// a predictor of the FIFO, link state and line coding. Depends on rtl/cacm_pkg.sv.
`timescale 1ns / 1ps

module cdc_acm_receive_and_control_tb;
  import cacm_pkg::*;

  localparam int RX_DEPTH = 256;
  localparam int HOLD_CYCLES = 800;
  localparam int BURST_BYTES = 36;
  localparam int DRAIN_POPS = 20;
  localparam int RANDOM_PER_PHASE = 12;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic [7:0] fill;
    logic       link;
    logic       dtr;
    logic       rts;
    logic       drop;
  } acm_result_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  ep;
    logic [3:0]  st;
    logic [7:0]  data;
    logic [7:0]  req;
    logic [15:0] val;
    logic        typed;
    logic [1:0]  kind;
    logic [7:0]  out;
    logic        valid;
    logic [7:0]  fill;
    logic        link;
    logic        dtr;
    logic        rts;
    logic        drop;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] baud;
    logic [1:0]  stop;
    logic [2:0]  parity;
    logic [4:0]  dbits;
  } line_coding_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_BAUD;
  logic [31:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = CMD_BUS_RESET;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  cdc_acm_receive_and_control #(.RX_DEPTH(RX_DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [7:0]   rx_mem [RX_DEPTH];
  int           wr_ptr = 0;
  int           rd_ptr = 0;
  logic         link_cfg = 1'b0;
  logic         bus_conn = 1'b0;
  logic         dtr_line = 1'b0;
  logic         rts_line = 1'b0;
  line_coding_t coding_regs = '{BAUD_RESET, 2'd0, 3'd0, CHAR_LEN_RESET};

  acm_result_t  pending_results[$];
  acm_result_t  step_results[$];

  int errors = 0;
  int n_requests = 0;
  int n_random = 0;
  int n_results = 0;
  int n_drops = 0;
  int n_coding = 0;
  int n_settings = 0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_start = 1'b0;
  int hold_left = 0;

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic acm_result_t acm_result(input logic [1:0] kind, input logic [7:0] b,
                                             input logic valid, input logic last,
                                             input logic drop);
    acm_result_t r;
    int fill;
    fill = (wr_ptr - rd_ptr + RX_DEPTH) % RX_DEPTH;
    r.kind = kind;
    r.data = b;
    r.valid = valid;
    r.last = last;
    r.fill = (fill > 255) ? 8'd255 : 8'(fill);
    r.link = link_cfg & bus_conn;
    r.dtr = dtr_line;
    r.rts = rts_line;
    r.drop = drop;
    return r;
  endfunction

  task automatic predict_request(input logic [2:0] cmd, input logic [3:0] ep,
                                 input logic [3:0] st, input logic [7:0] data,
                                 input logic [7:0] req, input logic [15:0] val);
    logic [7:0] coding [7];
    logic       drop;
    int         nxt;
    step_results.delete();
    drop = 1'b0;
    case (cmd)
      CMD_BUS_RESET: begin
        link_cfg = 1'b0;
        bus_conn = 1'b0;
        step_results.push_back(acm_result(KIND_ACK, 8'd0, 1'b0, 1'b1, 1'b0));
      end
      CMD_ENUM_DONE: begin
        bus_conn = 1'b1;
        step_results.push_back(acm_result(KIND_ACK, 8'd0, 1'b0, 1'b1, 1'b0));
      end
      CMD_DATA: begin
        if (ep == EP_DATA && st == PKT_OUT_DATA) begin
          nxt = (wr_ptr + 1) % RX_DEPTH;
          if (nxt != rd_ptr) begin
            rx_mem[wr_ptr] = data;
            wr_ptr = nxt;
          end else begin
            drop = 1'b1;
            n_drops++;
          end
        end
        step_results.push_back(acm_result(KIND_ACK, 8'd0, 1'b0, 1'b1, drop));
      end
      CMD_SETUP: begin
        if (ep == EP_CTRL && st == PKT_SETUP && req == REQ_GET_CODING) begin
          coding[0] = coding_regs.baud[7:0];
          coding[1] = coding_regs.baud[15:8];
          coding[2] = coding_regs.baud[23:16];
          coding[3] = coding_regs.baud[31:24];
          coding[4] = 8'(coding_regs.stop);
          coding[5] = 8'(coding_regs.parity);
          coding[6] = 8'(coding_regs.dbits);
          for (int k = 0; k < CODING_BYTES; k++)
            step_results.push_back(acm_result(KIND_CTRL_IN, coding[k], 1'b1,
                                              k == CODING_BYTES - 1, 1'b0));
          n_coding++;
        end else if (ep == EP_CTRL && st == PKT_SETUP && req == REQ_SET_CTRL) begin
          dtr_line = val[0];
          rts_line = val[1];
          link_cfg = 1'b1;
          step_results.push_back(acm_result(KIND_ZLP, 8'd0, 1'b0, 1'b1, 1'b0));
        end else begin
          step_results.push_back(acm_result(KIND_ACK, 8'd0, 1'b0, 1'b1, 1'b0));
        end
      end
      CMD_POP: begin
        if (wr_ptr == rd_ptr) begin
          step_results.push_back(acm_result(KIND_POP, 8'd0, 1'b0, 1'b1, 1'b0));
        end else begin
          data = rx_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % RX_DEPTH;
          step_results.push_back(acm_result(KIND_POP, data, 1'b1, 1'b1, 1'b0));
        end
      end
      default: begin
        step_results.push_back(acm_result(KIND_ACK, 8'd0, 1'b0, 1'b1, 1'b0));
      end
    endcase
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             n_results, name, got, want));
  endtask

  task automatic check_result();
    acm_result_t got;
    acm_result_t want;
    got.kind = m_axis_tuser;
    got.data = m_axis_tdata[7:0];
    got.valid = m_axis_tdata[8];
    got.last = m_axis_tlast;
    got.fill = m_axis_tdata[16:9];
    got.link = m_axis_tdata[17];
    got.dtr = m_axis_tdata[18];
    got.rts = m_axis_tdata[19];
    got.drop = m_axis_tdata[20];
    if (pending_results.size() == 0) begin
      report_error($sformatf("unexpected result kind %0d byte 0x%0h", got.kind, got.data));
    end else begin
      want = pending_results.pop_front();
      check_field("result_kind", got.kind, want.kind);
      check_field("out_byte", got.data, want.data);
      check_field("byte_valid", got.valid, want.valid);
      check_field("last_of_run", got.last, want.last);
      check_field("fill_count", got.fill, want.fill);
      check_field("link_up", got.link, want.link);
      check_field("dtr_out", got.dtr, want.dtr);
      check_field("rts_out", got.rts, want.rts);
      check_field("byte_dropped", got.drop, want.drop);
    end
    n_results++;
  endtask

  always @(posedge clk) begin
    if (hold_start)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      check_result();
    m_axis_tready <= !rst && hold_left == 0 && int'($urandom_range(0, 99)) >= rx_stall_pct;
  end

  task automatic send_request(input logic [2:0] cmd, input logic [3:0] ep,
                              input logic [3:0] st, input logic [7:0] data,
                              input logic [7:0] req, input logic [15:0] val,
                              input logic use_typed, input acm_result_t typed);
    while (int'($urandom_range(0, 99)) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {val, req, data, st, ep};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_request(cmd, ep, st, data, req, val);
    if (use_typed)
      pending_results.push_back(typed);
    else
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    n_requests++;
  endtask

  task automatic send_random(output logic counted);
    logic [2:0]  cmd;
    logic [3:0]  ep;
    logic [3:0]  st;
    logic [7:0]  data;
    logic [7:0]  req;
    logic [15:0] val;
    int          pick;
    cmd = 3'($urandom);
    ep = 4'($urandom);
    st = 4'($urandom);
    data = 8'($urandom);
    req = 8'($urandom);
    val = 16'($urandom);
    pick = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 35) begin
      cmd = CMD_DATA;
      ep = EP_DATA;
      st = PKT_OUT_DATA;
    end else if (pick < 60) begin
      cmd = CMD_POP;
    end else if (pick < 70) begin
      cmd = CMD_SETUP;
      ep = EP_CTRL;
      st = PKT_SETUP;
      req = REQ_GET_CODING;
    end else if (pick < 80) begin
      cmd = CMD_SETUP;
      ep = EP_CTRL;
      st = PKT_SETUP;
      req = REQ_SET_CTRL;
    end else if (pick < 84) begin
      cmd = CMD_ENUM_DONE;
    end else if (pick < 87) begin
      cmd = CMD_BUS_RESET;
    end else if (pick < 90) begin
      cmd = CMD_SETUP;
      ep = EP_CTRL;
      st = PKT_SETUP;
      req = REQ_SET_CODING;
      counted = 1'b0;
    end else begin
      counted = 1'b0;
    end
    send_request(cmd, ep, st, data, req, val, 1'b0, '0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_line_coding(input line_coding_t lc);
    cfg_we <= 1'b1;
    cfg_index <= REG_BAUD;
    cfg_data <= lc.baud;
    @(posedge clk);
    cfg_index <= REG_STOP_FMT;
    cfg_data <= 32'(lc.stop);
    @(posedge clk);
    cfg_index <= REG_PARITY;
    cfg_data <= 32'(lc.parity);
    @(posedge clk);
    cfg_index <= REG_CHAR_LEN;
    cfg_data <= 32'(lc.dbits);
    @(posedge clk);
    cfg_we <= 1'b0;
    coding_regs = lc;
    n_settings++;
  endtask

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    dir_row_t     directed_rows [25];
    dir_row_t     row;
    line_coding_t settings [4];
    int           tx_modes [4];
    int           rx_modes [4];
    int           counted_items;
    logic         counted;

    directed_rows = '{
      '{CMD_POP, 4'h0, 4'h0, 8'h00, 8'h00, 16'h0000,
        1'b1, KIND_POP, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_BUS_RESET, 4'hF, 4'hF, 8'hFF, 8'hFF, 16'hFFFF,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_SETUP, EP_CTRL, PKT_SETUP, 8'h00, REQ_GET_CODING, 16'h0000,
        1'b0, KIND_ACK, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_ENUM_DONE, 4'h0, 4'h0, 8'h00, 8'h00, 16'h0000,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_SETUP, EP_CTRL, PKT_SETUP, 8'h00, REQ_SET_CTRL, 16'hFFFF,
        1'b1, KIND_ZLP, 8'h00, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_DATA, EP_DATA, PKT_OUT_DATA, 8'hFF, 8'h00, 16'h0000,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd1, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_DATA, EP_DATA, PKT_OUT_DATA, 8'h00, 8'hFF, 16'hFFFF,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd2, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_DATA, EP_CTRL, PKT_OUT_DATA, 8'h5A, 8'h00, 16'h0000,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd2, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_DATA, EP_DATA, PKT_SETUP, 8'hA5, 8'h00, 16'h0000,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd2, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_DATA, 4'hF, 4'hF, 8'hFF, 8'hFF, 16'hFFFF,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd2, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_POP, 4'hF, 4'hF, 8'hFF, 8'hFF, 16'hFFFF,
        1'b1, KIND_POP, 8'hFF, 1'b1, 8'd1, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_POP, 4'h0, 4'h0, 8'h00, 8'h00, 16'h0000,
        1'b1, KIND_POP, 8'h00, 1'b1, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_POP, 4'h0, 4'h0, 8'h00, 8'h00, 16'h0000,
        1'b1, KIND_POP, 8'h00, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_SETUP, EP_DATA, PKT_SETUP, 8'h00, REQ_SET_CTRL, 16'h0000,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_SETUP, EP_CTRL, PKT_OUT_DATA, 8'h00, REQ_SET_CTRL, 16'h0000,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_SETUP, EP_CTRL, PKT_SETUP, 8'h00, REQ_SET_CODING, 16'h0000,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_SETUP, EP_CTRL, PKT_SETUP, 8'hFF, 8'hFF, 16'hFFFF,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_SETUP, EP_CTRL, PKT_SETUP, 8'h00, 8'h00, 16'h0000,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0},
      '{CMD_SETUP, EP_CTRL, PKT_SETUP, 8'h00, REQ_SET_CTRL, 16'h0002,
        1'b1, KIND_ZLP, 8'h00, 1'b0, 8'd0, 1'b1, 1'b0, 1'b1, 1'b0},
      '{CMD_SETUP, EP_CTRL, PKT_SETUP, 8'h00, REQ_SET_CTRL, 16'hFFFD,
        1'b1, KIND_ZLP, 8'h00, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0},
      '{CMD_SETUP, EP_CTRL, PKT_SETUP, 8'hFF, REQ_GET_CODING, 16'hFFFF,
        1'b0, KIND_ACK, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{CMD_BUS_RESET, 4'h0, 4'h0, 8'h00, 8'h00, 16'h0000,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0},
      '{CMD_UNUSED_LO, EP_DATA, PKT_OUT_DATA, 8'h33, REQ_SET_CTRL, 16'h0003,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0},
      '{CMD_UNUSED_HI, 4'hF, 4'hF, 8'hFF, 8'hFF, 16'hFFFF,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0},
      '{CMD_ENUM_DONE, 4'hF, 4'hF, 8'hFF, 8'hFF, 16'hFFFF,
        1'b1, KIND_ACK, 8'h00, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0}
    };

    settings[0] = '{32'd1, 2'd0, 3'd0, 5'd5};
    settings[1] = '{32'hFFFF_FFFF, 2'd2, 3'd4, 5'd16};
    settings[2] = '{32'hFFFF_FFFF, 2'd3, 3'd7, 5'd31};
    settings[3].baud = $urandom;
    settings[3].stop = 2'($urandom_range(0, 2));
    settings[3].parity = 3'($urandom_range(0, 4));
    settings[3].dbits = 5'($urandom_range(5, 16));
    tx_modes = '{0, 81, 0, 8};
    rx_modes = '{0, 0, 81, 8};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.cmd, row.ep, row.st, row.data, row.req, row.val, row.typed,
                   '{row.kind, row.out, row.valid, 1'b1, row.fill, row.link, row.dtr,
                     row.rts, row.drop});
    end

    // hold the result side while data keeps coming, then drain
    wait_drained();
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int i = 0; i < BURST_BYTES; i++)
      send_request(CMD_DATA, EP_DATA, PKT_OUT_DATA, 8'($urandom), 8'($urandom),
                   16'($urandom), 1'b0, '0);
    for (int i = 0; i < DRAIN_POPS; i++)
      send_request(CMD_POP, 4'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom), 1'b0, '0);

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_line_coding(settings[p]);
      tx_idle_pct = tx_modes[p];
      rx_stall_pct <= rx_modes[p];
      counted_items = 0;
      while (counted_items < RANDOM_PER_PHASE) begin
        send_random(counted);
        if (counted) counted_items++;
        n_random++;
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    $display("Run covered %0d requests (directed table, stalled burst and drain, %0d random)",
             n_requests, n_random);
    $display("%0d results checked, %0d line coding replies, %0d dropped bytes, %0d settings",
             n_results, n_coding, n_drops, n_settings);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors, %0d results missing", errors, pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
